// File: rtl/drpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drpe_pkg: shared types and constants of the dead-reckoning pose estimator
// Sequencer states, item kinds, register indexes and the sine table generator.
// ----------------------------------------------------------------------------
package drpe_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_FIN,
    ST_GPS_N,
    ST_GPS_E,
    ST_GPS_FIN,
    ST_MOT_SPD,
    ST_MOT_TRN,
    ST_MOT_COS,
    ST_MOT_SIN,
    ST_MOT_DX,
    ST_MOT_DY,
    ST_MOT_FIN,
    ST_WRITE
  } state_t;

  localparam logic [1:0] KIND_COMPASS = 2'd0;
  localparam logic [1:0] KIND_GPS     = 2'd1;
  localparam logic [1:0] KIND_MOTOR   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [2:0] REG_ORIGIN_LAT  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_LON  = 3'd2;
  localparam logic [2:0] REG_NORTH_SCALE = 3'd3;
  localparam logic [2:0] REG_EAST_SCALE  = 3'd4;
  localparam logic [2:0] REG_SPEED_GAIN  = 3'd5;
  localparam logic [2:0] REG_TURN_GAIN   = 3'd6;

  // round(cdeg * 65536 / 36000) equals floor((cdeg * 2048 + 562) / 1125);
  // take it as (cdeg * ceil(2^42 / 1125) + ceil(562 * 2^31 / 1125)) >> 31,
  // exact for every 16-bit cdeg.
  localparam logic signed [32:0] DIV_RECIP = 33'sd3909374677;
  localparam logic signed [51:0] DIV_BIAS  = 52'sd1072787387;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // Q30 odd polynomial for sin(pi/2 * t), scaled to Q1.15 and capped.
  function automatic logic [15:0] poly_sine(input longint unsigned t);
    longint unsigned t2;
    longint unsigned r;
    longint unsigned s;
    t2 = (t * t) >> 30;
    r  = 64'd172272;
    r  = 64'd5026995 - ((t2 * r) >> 30);
    r  = 64'd85569305 - ((t2 * r) >> 30);
    r  = 64'd693598668 - ((t2 * r) >> 30);
    r  = 64'd1686629713 - ((t2 * r) >> 30);
    s  = (t * r) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (s > 64'd32767) ? 16'd32767 : s[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/drpe_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drpe_mul: shared signed multiplier
// One 33 x 19 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module drpe_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [18:0] op_b,
  output logic signed [51:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

// File: rtl/dead_reckoning_pose_estimator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dead_reckoning_pose_estimator: planar pose tracker from compass, GPS, motors
// Sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transaction; kind
//   selects compass, GPS fix, motor step or no-op. Output channel
//   (out_valid/out_ready) returns one pose per input transaction, in order.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered and
//   must only happen while the block is idle.
// Work per item kind:
//   compass: one product by the reciprocal of 36000.
//   GPS fix: two products through the shared multiplier.
//   motor:   six dependent products through the shared multiplier.
//   no-op:   no product; the item goes straight to the write step.
//   One item is processed at a time; in_ready is high only when the
//   sequencer is idle, so a new item is taken only after the last one
//   has left the write step.
// Stall: the finished pose sits in the output register; the next item may be
//   accepted meanwhile and waits in the write step until the register frees.
// Reset: clears the pose, loads register defaults, drops any pending result.
//   The sine table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_estimator #(
  parameter int TRIG_TABLE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [15:0]        compass_cdeg,
  input  wire logic signed [30:0] fix_lat,
  input  wire logic signed [31:0] fix_lon,
  input  wire logic signed [8:0]  left_drive,
  input  wire logic signed [8:0]  right_drive,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pos_east,
  output logic signed [31:0]      pos_north,
  output logic signed [15:0]      heading_angle,
  output logic signed [15:0]      speed_out,
  output logic signed [15:0]      turn_out,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int IP_W  = 14 + IDX_W;

  // Configuration registers
  logic [15:0]        step_period;
  logic signed [30:0] origin_lat;
  logic signed [31:0] origin_lon;
  logic [17:0]        north_scale;
  logic [17:0]        east_scale;
  logic [15:0]        speed_gain;
  logic [15:0]        turn_gain;

  // Pose state
  logic signed [31:0] east_reg;
  logic signed [31:0] north_reg;
  logic [15:0]        heading_reg;
  logic signed [15:0] speed_reg;
  logic signed [15:0] turn_reg;

  // Captured item
  logic [1:0]         kind_r;
  logic [15:0]        cdeg_r;
  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;
  logic signed [8:0]  left_r;
  logic signed [8:0]  right_r;

  // Sequencer and scratch
  drpe_pkg::state_t   state;
  drpe_pkg::state_t   state_next;
  logic signed [32:0] tmp_a;
  logic signed [32:0] tmp_b;

  // Shared multiplier
  logic signed [32:0] op_a;
  logic signed [18:0] op_b;
  logic signed [51:0] prod;

  drpe_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Quarter-wave sine table, built at elaboration
  logic [15:0] sine_rom [TRIG_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= TRIG_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned TV = (longint'(gi) << 30) / TRIG_TABLE_DEPTH;
    assign sine_rom[gi] = drpe_pkg::poly_sine(TV);
  end

  // One table read per cycle: cosine uses the angle a quarter turn ahead
  logic [15:0]        trig_ang;
  logic [IP_W-1:0]    trig_scaled;
  logic [IDX_W-1:0]   trig_idx;
  logic [IDX_W-1:0]   trig_addr;
  logic signed [15:0] trig_mag;
  logic signed [15:0] trig_val;

  assign trig_ang    = (state == drpe_pkg::ST_MOT_COS) ?
                       heading_reg + drpe_pkg::QUARTER_TURN : heading_reg;
  assign trig_scaled = IP_W'(trig_ang[13:0]) * IP_W'(TRIG_TABLE_DEPTH);
  assign trig_idx    = trig_scaled[14 +: IDX_W];
  assign trig_addr   = trig_ang[14] ? IDX_W'(TRIG_TABLE_DEPTH) - trig_idx : trig_idx;
  assign trig_mag    = $signed(sine_rom[trig_addr]);
  assign trig_val    = trig_ang[15] ? -trig_mag : trig_mag;

  // Drive sum and difference
  logic signed [9:0] drv_sum;
  logic signed [9:0] drv_diff;
  assign drv_sum  = 10'(right_r) + 10'(left_r);
  assign drv_diff = 10'(right_r) - 10'(left_r);

  // Rounding and saturation of the registered product
  logic signed [51:0] rnd16;
  logic signed [51:0] rnd8;
  logic signed [51:0] rnd31;
  logic signed [51:0] pos_sum;
  logic signed [51:0] div_sum;
  logic signed [31:0] sat_r16;
  logic signed [15:0] sat_r16_16;
  logic signed [15:0] sat_r8;
  logic signed [31:0] sat_pos;

  assign rnd16   = (prod + (52'sd1 <<< 15)) >>> 16;
  assign rnd8    = (prod + (52'sd1 <<< 7)) >>> 8;
  assign rnd31   = (prod + (52'sd1 <<< 30)) >>> 31;
  assign pos_sum = ((state == drpe_pkg::ST_MOT_DY) ? 52'(east_reg) : 52'(north_reg)) + rnd31;
  // compass quotient sits in bits 46:31, taken modulo 2^16
  assign div_sum = prod + drpe_pkg::DIV_BIAS;

  always_comb begin
    if (rnd16 > 52'sd2147483647)       sat_r16 = 32'sh7FFFFFFF;
    else if (rnd16 < -52'sd2147483648) sat_r16 = 32'sh80000000;
    else                               sat_r16 = rnd16[31:0];
    if (rnd16 > 52'sd32767)            sat_r16_16 = 16'sh7FFF;
    else if (rnd16 < -52'sd32768)      sat_r16_16 = 16'sh8000;
    else                               sat_r16_16 = rnd16[15:0];
    if (rnd8 > 52'sd32767)             sat_r8 = 16'sh7FFF;
    else if (rnd8 < -52'sd32768)       sat_r8 = 16'sh8000;
    else                               sat_r8 = rnd8[15:0];
    if (pos_sum > 52'sd2147483647)       sat_pos = 32'sh7FFFFFFF;
    else if (pos_sum < -52'sd2147483648) sat_pos = 32'sh80000000;
    else                                 sat_pos = pos_sum[31:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      drpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            drpe_pkg::KIND_COMPASS: state_next = drpe_pkg::ST_DIV;
            drpe_pkg::KIND_GPS:     state_next = drpe_pkg::ST_GPS_N;
            drpe_pkg::KIND_MOTOR:   state_next = drpe_pkg::ST_MOT_SPD;
            drpe_pkg::KIND_NONE:    state_next = drpe_pkg::ST_WRITE;
          endcase
        end
      end
      drpe_pkg::ST_DIV:     state_next = drpe_pkg::ST_DIV_FIN;
      drpe_pkg::ST_DIV_FIN: state_next = drpe_pkg::ST_WRITE;
      drpe_pkg::ST_GPS_N:   state_next = drpe_pkg::ST_GPS_E;
      drpe_pkg::ST_GPS_E:   state_next = drpe_pkg::ST_GPS_FIN;
      drpe_pkg::ST_GPS_FIN: state_next = drpe_pkg::ST_WRITE;
      drpe_pkg::ST_MOT_SPD: state_next = drpe_pkg::ST_MOT_TRN;
      drpe_pkg::ST_MOT_TRN: state_next = drpe_pkg::ST_MOT_COS;
      drpe_pkg::ST_MOT_COS: state_next = drpe_pkg::ST_MOT_SIN;
      drpe_pkg::ST_MOT_SIN: state_next = drpe_pkg::ST_MOT_DX;
      drpe_pkg::ST_MOT_DX:  state_next = drpe_pkg::ST_MOT_DY;
      drpe_pkg::ST_MOT_DY:  state_next = drpe_pkg::ST_MOT_FIN;
      drpe_pkg::ST_MOT_FIN: state_next = drpe_pkg::ST_WRITE;
      drpe_pkg::ST_WRITE:   if (!out_valid || out_ready) state_next = drpe_pkg::ST_IDLE;
      default:              state_next = drpe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand selection
  always_comb begin
    in_ready = 1'b0;
    op_a     = '0;
    op_b     = '0;
    unique case (state)
      drpe_pkg::ST_IDLE:  in_ready = 1'b1;
      drpe_pkg::ST_DIV: begin
        op_a = drpe_pkg::DIV_RECIP;
        op_b = $signed({3'b0, cdeg_r});
      end
      drpe_pkg::ST_GPS_N: begin
        op_a = 33'(lat_r) - 33'(origin_lat);
        op_b = $signed({1'b0, north_scale});
      end
      drpe_pkg::ST_GPS_E: begin
        op_a = 33'(lon_r) - 33'(origin_lon);
        op_b = $signed({1'b0, east_scale});
      end
      drpe_pkg::ST_MOT_SPD: begin
        op_a = 33'(drv_sum);
        op_b = $signed({3'b0, speed_gain});
      end
      drpe_pkg::ST_MOT_TRN: begin
        op_a = 33'(drv_diff);
        op_b = $signed({3'b0, turn_gain});
      end
      drpe_pkg::ST_MOT_COS, drpe_pkg::ST_MOT_SIN: begin
        op_a = 33'(speed_reg);
        op_b = 19'(trig_val);
      end
      drpe_pkg::ST_MOT_DX: begin
        op_a = tmp_a;
        op_b = $signed({3'b0, step_period});
      end
      drpe_pkg::ST_MOT_DY: begin
        op_a = tmp_b;
        op_b = $signed({3'b0, step_period});
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= drpe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == drpe_pkg::ST_WRITE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= 16'd6554;
      origin_lat  <= '0;
      origin_lon  <= '0;
      north_scale <= 18'd186546;
      east_scale  <= 18'd186546;
      speed_gain  <= 16'd256;
      turn_gain   <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drpe_pkg::REG_STEP_PERIOD: step_period <= cfg_data[15:0];
        drpe_pkg::REG_ORIGIN_LAT:  origin_lat  <= $signed(cfg_data[30:0]);
        drpe_pkg::REG_ORIGIN_LON:  origin_lon  <= $signed(cfg_data);
        drpe_pkg::REG_NORTH_SCALE: north_scale <= cfg_data[17:0];
        drpe_pkg::REG_EAST_SCALE:  east_scale  <= cfg_data[17:0];
        drpe_pkg::REG_SPEED_GAIN:  speed_gain  <= cfg_data[15:0];
        drpe_pkg::REG_TURN_GAIN:   turn_gain   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      east_reg    <= '0;
      north_reg   <= '0;
      heading_reg <= '0;
      speed_reg   <= '0;
      turn_reg    <= '0;
    end else begin
      unique case (state)
        // turn the compass quotient into an east-based, counter-clockwise angle
        drpe_pkg::ST_DIV_FIN: heading_reg <= drpe_pkg::QUARTER_TURN - div_sum[46:31];
        drpe_pkg::ST_GPS_E:   north_reg <= sat_r16;
        drpe_pkg::ST_GPS_FIN: east_reg  <= sat_r16;
        drpe_pkg::ST_MOT_TRN: speed_reg <= sat_r8;
        drpe_pkg::ST_MOT_COS: turn_reg  <= sat_r16_16;
        drpe_pkg::ST_MOT_DY:  east_reg  <= sat_pos;
        drpe_pkg::ST_MOT_FIN: begin
          north_reg   <= sat_pos;
          heading_reg <= heading_reg + turn_reg;
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture and product holding registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= kind;
      cdeg_r  <= compass_cdeg;
      lat_r   <= fix_lat;
      lon_r   <= fix_lon;
      left_r  <= left_drive;
      right_r <= right_drive;
    end
    if (state == drpe_pkg::ST_MOT_SIN) tmp_a <= prod[32:0];
    if (state == drpe_pkg::ST_MOT_DX)  tmp_b <= prod[32:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == drpe_pkg::ST_WRITE && (!out_valid || out_ready)) begin
      pos_east      <= east_reg;
      pos_north     <= north_reg;
      heading_angle <= $signed(heading_reg);
      speed_out     <= speed_reg;
      turn_out      <= turn_reg;
    end
  end

`ifndef SYNTHESIS
  a_none_to_write: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == drpe_pkg::KIND_NONE |=> state == drpe_pkg::ST_WRITE)
    else $error("no-op item did not go straight to write");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    state == drpe_pkg::ST_DIV |=> state == drpe_pkg::ST_DIV_FIN)
    else $error("compass product not followed by its finish step");
  a_gps_heading: assert property (@(posedge clk) disable iff (rst)
    state == drpe_pkg::ST_GPS_N |=> $stable(heading_reg))
    else $error("GPS item changed heading");
  a_write_hold: assert property (@(posedge clk) disable iff (rst)
    state == drpe_pkg::ST_WRITE && out_valid && !out_ready |=> state == drpe_pkg::ST_WRITE)
    else $error("result dropped while output stalled");
  a_motor_kind: assert property (@(posedge clk) disable iff (rst)
    state == drpe_pkg::ST_MOT_SPD |-> kind_r == drpe_pkg::KIND_MOTOR)
    else $error("motor sequence for wrong kind");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dead-reckoning pose estimator
// Drives compass, GPS, motor and no-op items through the valid/ready input,
// predicts each pose in fixed point and compares it against the output port.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TAB_DEPTH = 256;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        cdeg;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [8:0]  left;
    logic signed [8:0]  right;
  } item_t;

  typedef struct packed {
    logic signed [31:0] east;
    logic signed [31:0] north;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [15:0] compass_cdeg = '0;
  logic signed [30:0] fix_lat = '0;
  logic signed [31:0] fix_lon = '0;
  logic signed [8:0] left_drive = '0;
  logic signed [8:0] right_drive = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_east, pos_north;
  logic signed [15:0] heading_angle, speed_out, turn_out;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  dead_reckoning_pose_estimator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .compass_cdeg(compass_cdeg), .fix_lat(fix_lat), .fix_lon(fix_lon),
    .left_drive(left_drive), .right_drive(right_drive),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_east(pos_east), .pos_north(pos_north), .heading_angle(heading_angle),
    .speed_out(speed_out), .turn_out(turn_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the configuration and pose state.
  longint unsigned period_q16, nscale, escale, spd_gain, trn_gain;
  longint org_lat, org_lon;
  logic signed [31:0] east_q, north_q;
  logic [15:0] heading_q;
  logic signed [15:0] speed_q, turn_q;
  longint sine_rom [0:TAB_DEPTH];

  item_t item_queue[$];
  pose_t pose_queue[$];
  int send_idle_pct = 31;
  int recv_idle_pct = 70;
  int hold_requests = 0;
  int hold_done = 0;
  int hold_cnt = 0;
  int errors = 0;
  logic in_ready_seen = 1'b0;

  // Round to nearest, ties upward: floor((v + 2^(k-1)) / 2^k).
  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sine_lookup(input logic [15:0] u);
    logic [1:0] quad;
    int idx;
    longint v;
    quad = u[15:14];
    idx = (int'(u[13:0]) * TAB_DEPTH) >> 14;
    v = quad[0] ? sine_rom[TAB_DEPTH - idx] : sine_rom[idx];
    return quad[1] ? -v : v;
  endfunction

  task automatic load_defaults();
    period_q16 = 6554; org_lat = 0; org_lon = 0;
    nscale = 186546; escale = 186546; spd_gain = 256; trn_gain = 256;
    east_q = 0; north_q = 0; heading_q = 0; speed_q = 0; turn_q = 0;
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      longint unsigned t, t2, r, s;
      t = (longint'(i) << 30) / TAB_DEPTH;
      t2 = (t * t) >> 30;
      r = 172272;
      r = 5026995 - ((t2 * r) >> 30);
      r = 85569305 - ((t2 * r) >> 30);
      r = 693598668 - ((t2 * r) >> 30);
      r = 1686629713 - ((t2 * r) >> 30);
      s = (t * r) >> 30;
      s = (s * 32767 + (longint'(1) << 29)) >> 30;
      sine_rom[i] = s > 32767 ? 32767 : s;
    end
  endtask

  // Advance the pose by one item and queue the pose it reports.
  task automatic advance_pose(input item_t it);
    longint a, dl, c, s;
    pose_t p;
    case (it.kind)
      drpe_pkg::KIND_COMPASS: begin
        a = (longint'(it.cdeg) * 65536 + 18000) / 36000;
        heading_q = 16'(longint'(drpe_pkg::QUARTER_TURN) - a);
      end
      drpe_pkg::KIND_GPS: begin
        dl = longint'(it.lat) - org_lat;
        north_q = 32'(clamp(round_shift(dl * longint'(nscale), 16), -(64'sd1 <<< 31),
                            (64'sd1 <<< 31) - 1));
        dl = longint'(it.lon) - org_lon;
        east_q = 32'(clamp(round_shift(dl * longint'(escale), 16), -(64'sd1 <<< 31),
                           (64'sd1 <<< 31) - 1));
      end
      drpe_pkg::KIND_MOTOR: begin
        speed_q = 16'(clamp(round_shift((longint'(it.right) + longint'(it.left))
                                        * longint'(spd_gain), 8), -32768, 32767));
        turn_q = 16'(clamp(round_shift((longint'(it.right) - longint'(it.left))
                                       * longint'(trn_gain), 16), -32768, 32767));
        c = sine_lookup(heading_q + drpe_pkg::QUARTER_TURN);
        s = sine_lookup(heading_q);
        east_q = 32'(clamp(longint'(east_q) + round_shift(longint'(speed_q) * c
                 * longint'(period_q16), 31), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        north_q = 32'(clamp(longint'(north_q) + round_shift(longint'(speed_q) * s
                  * longint'(period_q16), 31), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        heading_q = heading_q + turn_q;
      end
      default: ;
    endcase
    p.east = east_q; p.north = north_q; p.heading = heading_q;
    p.speed = speed_q; p.turn = turn_q;
    pose_queue.push_back(p);
  endtask

  // Driver: present queued items at the falling edge, hold until accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_t it;
          it = item_queue.pop_front();
          kind <= it.kind; compass_cdeg <= it.cdeg; fix_lat <= it.lat;
          fix_lon <= it.lon; left_drive <= it.left; right_drive <= it.right;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_requests != hold_done) begin
        hold_done <= hold_done + 1;
        hold_cnt <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Capture acceptances at the rising edge; predict on each accepted input.
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      item_t it;
      in_ready_seen <= 1'b1;
      it.kind = kind; it.cdeg = compass_cdeg; it.lat = fix_lat; it.lon = fix_lon;
      it.left = left_drive; it.right = right_drive;
      advance_pose(it);
    end
  end

  // Monitor: compare each delivered pose against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $error("pose delivered with none expected");
        errors++;
      end else begin
        pose_t e;
        e = pose_queue.pop_front();
        if (pos_east !== e.east) begin
          $error("pos_east: expected %0d, got %0d", e.east, pos_east); errors++;
        end
        if (pos_north !== e.north) begin
          $error("pos_north: expected %0d, got %0d", e.north, pos_north); errors++;
        end
        if (heading_angle !== e.heading) begin
          $error("heading_angle: expected %0d, got %0d", e.heading, heading_angle);
          errors++;
        end
        if (speed_out !== e.speed) begin
          $error("speed_out: expected %0d, got %0d", e.speed, speed_out); errors++;
        end
        if (turn_out !== e.turn) begin
          $error("turn_out: expected %0d, got %0d", e.turn, turn_out); errors++;
        end
      end
    end
  end

  function automatic item_t random_item();
    item_t it;
    int r;
    it.kind = $urandom_range(99) < 3 ? drpe_pkg::KIND_NONE : 2'($urandom_range(2));
    r = $urandom_range(9);
    it.cdeg = r == 0 ? 16'($urandom) : 16'($urandom_range(35999));
    it.lat = r == 1 ? 31'($urandom) : 31'($signed($urandom_range(2000000)) - 1000000);
    it.lon = r == 2 ? 32'($urandom) : 32'($signed($urandom_range(2000000)) - 1000000);
    it.left = r == 3 ? 9'($urandom) : 9'($signed($urandom_range(510)) - 255);
    it.right = r == 4 ? 9'($urandom) : 9'($signed($urandom_range(510)) - 255);
    return it;
  endfunction

  function automatic item_t make_item(input logic [1:0] k, input logic [15:0] cd,
                                      input logic [30:0] la, input logic [31:0] lo,
                                      input logic [8:0] l, input logic [8:0] r);
    item_t it;
    it.kind = k; it.cdeg = cd; it.lat = la; it.lon = lo; it.left = l; it.right = r;
    return it;
  endfunction

  // Wait until the queues drain, then let the block settle.
  task automatic drain();
    while (item_queue.size() > 0 || in_valid || pose_queue.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write one register while the block is idle, keep the shadow in step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drpe_pkg::REG_STEP_PERIOD: period_q16 = val[15:0];
      drpe_pkg::REG_ORIGIN_LAT:  org_lat = longint'($signed(val[30:0]));
      drpe_pkg::REG_ORIGIN_LON:  org_lon = longint'($signed(val));
      drpe_pkg::REG_NORTH_SCALE: nscale = val[17:0];
      drpe_pkg::REG_EAST_SCALE:  escale = val[17:0];
      drpe_pkg::REG_SPEED_GAIN:  spd_gain = val[15:0];
      drpe_pkg::REG_TURN_GAIN:   trn_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) item_queue.push_back(random_item());
  endtask

  initial begin
    load_defaults();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every kind, wrapping compass, saturation.
    item_queue.push_back(make_item(drpe_pkg::KIND_COMPASS, 16'd0, 0, 0, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_COMPASS, 16'd35999, 0, 0, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_COMPASS, 16'hFFFF, 0, 0, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_COMPASS, 16'd9000, 0, 0, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_MOTOR, 0, 0, 0, 9'sd255, 9'sd255));
    item_queue.push_back(make_item(drpe_pkg::KIND_MOTOR, 0, 0, 0, 9'h100, 9'sd255));
    item_queue.push_back(make_item(drpe_pkg::KIND_MOTOR, 0, 0, 0, 9'h100, 9'h100));
    item_queue.push_back(make_item(drpe_pkg::KIND_GPS, 0, 31'sd900000000,
                                   32'sd1800000000, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_GPS, 0, 31'h40000000, 32'h80000000,
                                   0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_GPS, 0, 31'h3FFFFFFF, 32'h7FFFFFFF,
                                   0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_NONE, 16'hFFFF, 31'h7FFFFFFF,
                                   32'hFFFFFFFF, 9'h1FF, 9'h1FF));
    item_queue.push_back(make_item(drpe_pkg::KIND_COMPASS, 16'd18000, 0, 0, 0, 0));
    item_queue.push_back(make_item(drpe_pkg::KIND_MOTOR, 0, 0, 0, 9'sd100, -9'sd100));
    drain();

    // Extreme gains and period to drive speed, turn and position into saturation.
    write_reg(drpe_pkg::REG_STEP_PERIOD, 32'hFFFF);
    write_reg(drpe_pkg::REG_SPEED_GAIN, 32'hFFFF);
    write_reg(drpe_pkg::REG_TURN_GAIN, 32'hFFFF);
    write_reg(drpe_pkg::REG_NORTH_SCALE, 32'h3FFFF);
    write_reg(drpe_pkg::REG_EAST_SCALE, 32'h3FFFF);
    write_reg(drpe_pkg::REG_ORIGIN_LAT, 32'(-31'sd900000000));
    write_reg(drpe_pkg::REG_ORIGIN_LON, 32'sd1800000000);
    send_idle_pct = 31; recv_idle_pct = 70;
    random_burst(300);
    drain();

    write_reg(drpe_pkg::REG_STEP_PERIOD, 0);
    write_reg(drpe_pkg::REG_SPEED_GAIN, 0);
    write_reg(drpe_pkg::REG_TURN_GAIN, 0);
    write_reg(drpe_pkg::REG_NORTH_SCALE, 0);
    write_reg(drpe_pkg::REG_EAST_SCALE, 0);
    write_reg(drpe_pkg::REG_ORIGIN_LAT, 0);
    write_reg(drpe_pkg::REG_ORIGIN_LON, 0);
    send_idle_pct = 70; recv_idle_pct = 31;
    random_burst(200);
    drain();

    // Typical settings; stall the receiver long while items keep coming.
    write_reg(drpe_pkg::REG_STEP_PERIOD, 6554);
    write_reg(drpe_pkg::REG_SPEED_GAIN, 300);
    write_reg(drpe_pkg::REG_TURN_GAIN, 20000);
    write_reg(drpe_pkg::REG_NORTH_SCALE, 186546);
    write_reg(drpe_pkg::REG_EAST_SCALE, 150000);
    write_reg(drpe_pkg::REG_ORIGIN_LAT, 32'(31'sd341000000));
    write_reg(drpe_pkg::REG_ORIGIN_LON, 32'(-32'sd1177000000));
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_requests++;
    random_burst(300);
    // Pause the sender until every pose has come back.
    drain();
    random_burst(400);
    drain();

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
